[sv/rwhs_pkg.sv]
// Package for the readout word hit sorter: slot counts, phase and operation
// codes, and the operation record that travels from front to back.
// No dependencies.
package rwhs_pkg;

  localparam int unsigned HIT_SLOTS     = 48;
  localparam int unsigned TRIGGER_SLOTS = 16;
  localparam int unsigned HIT_CNT_W     = $clog2(HIT_SLOTS);
  localparam int unsigned TRIG_CNT_W    = $clog2(TRIGGER_SLOTS);

  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

  localparam logic [3:0] TYPE_HIT   = 4'b0001;
  localparam logic [3:0] TYPE_EXT   = 4'b0010;
  localparam int unsigned LEN_W     = 13;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_MODHDR = 2'd1,
    PH_DATA   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_HIT    = 3'd2,
    OP_EXT    = 3'd3,
    OP_EVT    = 3'd4,
    OP_BROKEN = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    CAT_LONG  = 2'd0,
    CAT_SHORT = 2'd1,
    CAT_TDIFF = 2'd2,
    CAT_TRIG  = 2'd3
  } cat_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_HIT    = 3'd1,
    KIND_EXT    = 3'd2,
    KIND_EVT    = 3'd3,
    KIND_BROKEN = 3'd4
  } kind_e;

  typedef struct packed {
    op_e         op;
    cat_e        cat;
    logic [3:0]  ch;
    logic [29:0] data;
  } op_t;

endpackage

[sv/readout_word_hit_sorter_unit.sv]
// Top level of the readout word hit sorter: front decode, operation queue
// and back counters. Depends on rwhs_pkg, rwhs_front, rwhs_queue, rwhs_back.
//
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------
//   in      | in_valid_i / in_ready_o   | mode_i, word_i
//   out     | out_valid_o / out_ready_i | kind_o .. broken_events_o
//
// One word per cycle while the queue is not full. A word is decoded in the
// cycle it is taken; its result is registered into a queue entry, then into
// the output register. The two-entry queue lets the input keep flowing for
// two words while the output stalls; in_ready_o drops only when the queue is full.
// Reset clears framing, counts, timestamps and the broken-event count.
module readout_word_hit_sorter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [31:0] word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [1:0]  category_o,
  output logic [3:0]  channel_o,
  output logic [15:0] sample_o,
  output logic [5:0]  slot_o,
  output logic [5:0]  hit_count_o,
  output logic [29:0] event_time_o,
  output logic [15:0] extended_time_o,
  output logic [31:0] broken_events_o
);
  import rwhs_pkg::*;

  logic q_full, q_empty, push, pop;
  op_t  push_op, head_op;

  assign in_ready_o = !q_full;

  rwhs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .q_full_i   (q_full),
    .mode_i     (mode_i),
    .word_i     (word_i),
    .push_o     (push),
    .op_o       (push_op)
  );

  rwhs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .full_o    (q_full),
    .empty_o   (q_empty),
    .head_o    (head_op)
  );

  rwhs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .op_i            (head_op),
    .pop_o           (pop),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .category_o      (category_o),
    .channel_o       (channel_o),
    .sample_o        (sample_o),
    .slot_o          (slot_o),
    .hit_count_o     (hit_count_o),
    .event_time_o    (event_time_o),
    .extended_time_o (extended_time_o),
    .broken_events_o (broken_events_o)
  );

endmodule

[sv/rwhs_front.sv]
// Front part of the readout word hit sorter: block framing and word decode.
// Depends on rwhs_pkg; emits one op_t per accepted word.
module rwhs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              q_full_i,
  input  logic              mode_i,
  input  logic [31:0]       word_i,
  output logic              push_o,
  output rwhs_pkg::op_t     op_o
);
  import rwhs_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] words_left_q, words_left_d;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] left_dec;
  logic [5:0]       chan;

  assign push_o   = in_valid_i && !q_full_i;
  assign len      = word_i[LEN_W-1:0];
  assign chan     = word_i[21:16];
  assign left_dec = (words_left_q != '0) ? words_left_q - 1'b1 : words_left_q;

  // Next state: framing only; a new-event item leaves framing untouched.
  always_comb begin
    phase_d      = phase_q;
    words_left_d = words_left_q;
    if (!mode_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (len > LEN_W'(1)) begin
            words_left_d = len - 1'b1;
            phase_d      = PH_MODHDR;
          end else if (len == LEN_W'(1)) begin
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP:   phase_d = PH_HEADER;
        PH_MODHDR: phase_d = (words_left_q != '0) ? PH_DATA : PH_HEADER;
        PH_DATA: begin
          words_left_d = left_dec;
          if (left_dec == '0) phase_d = PH_HEADER;
        end
        default:   phase_d = PH_HEADER;
      endcase
    end
  end

  // Output: classify the word into an operation for the back part.
  always_comb begin
    op_o      = '0;
    op_o.op   = OP_NONE;
    op_o.cat  = CAT_LONG;
    op_o.ch   = chan[3:0];
    op_o.data = word_i[29:0];
    if (mode_i) begin
      op_o.op = OP_CLEAR;
    end else if (phase_q == PH_SKIP) begin
      op_o.op = OP_BROKEN;
    end else if (phase_q == PH_DATA) begin
      if (word_i[31:28] == TYPE_HIT) begin
        op_o.op = OP_HIT;
        priority if (chan < 6'd16) op_o.cat = CAT_LONG;
        else if (chan < 6'd32)     op_o.cat = CAT_TDIFF;
        else if (chan < 6'd34)     op_o.cat = CAT_TRIG;
        else if (chan >= 6'd48)    op_o.cat = CAT_SHORT;
        else                       op_o.op  = OP_NONE;
      end else if (word_i[31:28] == TYPE_EXT) begin
        op_o.op = OP_EXT;
      end else if (word_i[31:30] == 2'b11) begin
        op_o.op = OP_EVT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      words_left_q <= '0;
    end else if (push_o) begin
      phase_q      <= phase_d;
      words_left_q <= words_left_d;
    end
  end

endmodule

[sv/rwhs_queue.sv]
// Short queue of decoded operations between front and back.
// Depends on rwhs_pkg for op_t and the queue depth.
module rwhs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rwhs_pkg::op_t push_op_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output rwhs_pkg::op_t head_o
);
  import rwhs_pkg::*;

  op_t                entries_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCOUNT_W-1:0] count_q;

  assign full_o  = (count_q == QCOUNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= push_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

[sv/rwhs_back.sv]
// Back part of the readout word hit sorter: slot counters, timestamps,
// broken-event count and the output register. Depends on rwhs_pkg.
module rwhs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rwhs_pkg::op_t op_i,
  output logic          pop_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [2:0]    kind_o,
  output logic [1:0]    category_o,
  output logic [3:0]    channel_o,
  output logic [15:0]   sample_o,
  output logic [5:0]    slot_o,
  output logic [5:0]    hit_count_o,
  output logic [29:0]   event_time_o,
  output logic [15:0]   extended_time_o,
  output logic [31:0]   broken_events_o
);
  import rwhs_pkg::*;

  localparam logic [HIT_CNT_W-1:0]  HitLast  = HIT_CNT_W'(HIT_SLOTS - 1);
  localparam logic [TRIG_CNT_W-1:0] TrigLast = TRIG_CNT_W'(TRIGGER_SLOTS - 1);

  logic [HIT_CNT_W-1:0]  long_q, long_d, short_q, short_d, tdiff_q, tdiff_d;
  logic [TRIG_CNT_W-1:0] trig_q, trig_d;
  logic [15:0]           ext_q, ext_d;
  logic [29:0]           evt_q, evt_d;
  logic [31:0]           broken_q, broken_d;

  kind_e       kind_n;
  logic [1:0]  cat_n;
  logic [3:0]  ch_n;
  logic [15:0] val_n;
  logic [5:0]  slot_n, cnt_n;

  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [1:0]  cat_q;
  logic [3:0]  ch_q;
  logic [15:0] val_q;
  logic [5:0]  slot_q, cnt_q;
  logic [29:0] evt_out_q;
  logic [15:0] ext_out_q;
  logic [31:0] broken_out_q;

  assign pop_o = !q_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    long_d   = long_q;
    short_d  = short_q;
    tdiff_d  = tdiff_q;
    trig_d   = trig_q;
    ext_d    = ext_q;
    evt_d    = evt_q;
    broken_d = broken_q;
    kind_n   = KIND_NONE;
    cat_n    = '0;
    ch_n     = '0;
    val_n    = '0;
    slot_n   = '0;
    cnt_n    = '0;
    unique case (op_i.op)
      OP_NONE: ;
      OP_CLEAR: begin
        long_d  = '0;
        short_d = '0;
        tdiff_d = '0;
        trig_d  = '0;
        ext_d   = '0;
        evt_d   = '0;
      end
      OP_HIT: begin
        kind_n = KIND_HIT;
        cat_n  = op_i.cat;
        ch_n   = op_i.ch;
        val_n  = op_i.data[15:0];
        // Take the current count as slot; saturate on the last slot.
        unique case (op_i.cat)
          CAT_LONG: begin
            slot_n = 6'(long_q);
            long_d = (long_q == HitLast) ? long_q : long_q + 1'b1;
            cnt_n  = 6'(long_d);
          end
          CAT_SHORT: begin
            slot_n  = 6'(short_q);
            short_d = (short_q == HitLast) ? short_q : short_q + 1'b1;
            cnt_n   = 6'(short_d);
          end
          CAT_TDIFF: begin
            slot_n  = 6'(tdiff_q);
            tdiff_d = (tdiff_q == HitLast) ? tdiff_q : tdiff_q + 1'b1;
            cnt_n   = 6'(tdiff_d);
          end
          CAT_TRIG: begin
            slot_n = 6'(trig_q);
            trig_d = (trig_q == TrigLast) ? trig_q : trig_q + 1'b1;
            cnt_n  = 6'(trig_d);
          end
          default: ;
        endcase
      end
      OP_EXT: begin
        kind_n = KIND_EXT;
        ext_d  = op_i.data[15:0];
      end
      OP_EVT: begin
        kind_n = KIND_EVT;
        evt_d  = op_i.data;
      end
      OP_BROKEN: begin
        kind_n   = KIND_BROKEN;
        broken_d = (&broken_q) ? broken_q : broken_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q      <= '0;
      short_q     <= '0;
      tdiff_q     <= '0;
      trig_q      <= '0;
      ext_q       <= '0;
      evt_q       <= '0;
      broken_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        long_q      <= long_d;
        short_q     <= short_d;
        tdiff_q     <= tdiff_d;
        trig_q      <= trig_d;
        ext_q       <= ext_d;
        evt_q       <= evt_d;
        broken_q    <= broken_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q       <= kind_n;
      cat_q        <= cat_n;
      ch_q         <= ch_n;
      val_q        <= val_n;
      slot_q       <= slot_n;
      cnt_q        <= cnt_n;
      evt_out_q    <= evt_d;
      ext_out_q    <= ext_d;
      broken_out_q <= broken_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign category_o      = cat_q;
  assign channel_o       = ch_q;
  assign sample_o        = val_q;
  assign slot_o          = slot_q;
  assign hit_count_o     = cnt_q;
  assign event_time_o    = evt_out_q;
  assign extended_time_o = ext_out_q;
  assign broken_events_o = broken_out_q;

endmodule
